/* sv/fcca_pkg.sv */
// Shared types and constants of the FAT cluster chain allocator.
// No dependencies.
package fcca_pkg;

  localparam int unsigned DefNumClusters = 256;
  localparam int unsigned DefNumFiles    = 64;
  localparam int unsigned DefClusterBytes = 512;

  localparam int unsigned Handles = 64;   // handle space of the 6-bit ids
  localparam int unsigned ClW     = 12;   // cluster link width
  localparam int unsigned SizeW   = 15;
  localparam int unsigned QuoW    = 16;   // ceil(size / cluster) result width

  localparam logic [ClW-1:0]   EndMark   = 12'hFFF;
  localparam logic [SizeW-1:0] RootBytes = 15'd512;

  typedef enum logic [2:0] {
    ACT_NEW    = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_RENAME = 3'd2,
    ACT_COPY   = 3'd3,
    ACT_MODIFY = 3'd4
  } action_e;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StUsed    = 2'd1;
  localparam logic [1:0] StMissing = 2'd2;
  localparam logic [1:0] StNoSpace = 2'd3;

  typedef struct packed {
    logic             start;
    logic [QuoW-1:0]  dividend;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QuoW-1:0]  quotient;
  } div_rsp_t;

endpackage

/* sv/fcca_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read port.
// Uses fcca_pkg for its parameter defaults.
module fcca_ram
  import fcca_pkg::*;
#(
  parameter int unsigned Width = ClW,
  parameter int unsigned Depth = DefNumClusters,
  localparam int unsigned AW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* sv/fcca_div.sv */
// Divide by the fixed cluster size through a reciprocal multiply; the quotient is registered.
// Depends on fcca_pkg.
module fcca_div
  import fcca_pkg::*;
#(
  parameter int unsigned ClusterBytes = DefClusterBytes
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  // ceil(2^31 / ClusterBytes): exact for every dividend below 2^16
  localparam logic [31:0] Recip =
    32'(((64'd1 << 31) + 64'(ClusterBytes) - 64'd1) / 64'(ClusterBytes));

  logic [47:0]     prod;
  logic [QuoW-1:0] quo_q, quo_d;
  logic            done_q, done_d;

  assign prod   = 48'(req_i.dividend) * 48'(Recip);
  assign quo_d  = QuoW'(prod >> 31);
  assign done_d = req_i.start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

/* sv/fat_cluster_chain_allocator.sv */
// FAT cluster chain allocator: sequencer, link table and directory memories.
// Depends on fcca_pkg, fcca_ram, fcca_div.
//
// Usage:
//   s_axis carries one command word (action, file_id, other_id, size_bytes);
//   m_axis returns one result word (status, first_cluster, cluster_count)
//   for every command, in order.
//   One command is worked at a time. A command passes a directory read and
//   check, the size-to-cluster divide and a first-fit scan of up to
//   NUM_CLUSTERS-1 clusters (new, copy, modify), a walk of the old chain
//   when one is freed (delete, modify; at most ceil(32767/CLUSTER_BYTES)
//   links), then commit and result. Each cluster check and each link
//   walked waits for a registered read of the link memory.
//   After reset a clearing pass writes every link entry, during which
//   s_axis_tready stays low; the root handle 0 is set up then.
//   The result sits in an output register: a stalled receiver holds it, and
//   the next command is still accepted and worked; its result waits until
//   the register is free.
module fat_cluster_chain_allocator
  import fcca_pkg::*;
#(
  parameter int unsigned NUM_CLUSTERS  = DefNumClusters,
  parameter int unsigned NUM_FILES     = DefNumFiles,
  parameter int unsigned CLUSTER_BYTES = DefClusterBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] action, [8:3] file_id, [14:9] other_id, [29:15] size_bytes
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [13:2] first_cluster, [22:14] cluster_count
  output logic [23:0] m_axis_tdata
);

  localparam int unsigned CW       = $clog2(NUM_CLUSTERS);
  localparam int unsigned DirDepth = (NUM_FILES < Handles) ? NUM_FILES : Handles;
  localparam int unsigned DW       = $clog2(DirDepth);
  localparam logic [ClW-1:0] NumCl = ClW'(NUM_CLUSTERS);
  localparam int unsigned DirW     = SizeW + ClW;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DREAD, S_CHECK, S_DIV, S_SCAN_RD, S_SCAN_CHK, S_SCAN_END,
    S_DROP_RD, S_DROP_CHK, S_COMMIT, S_DONE
  } state_e;

  state_e state_q, state_d;

  logic [2:0]       act_q, act_d;
  logic [5:0]       fid_q, fid_d, oid_q, oid_d;
  logic [SizeW-1:0] size_q, size_d, rd_size_q, rd_size_d;
  logic [ClW-1:0]   rd_first_q, rd_first_d, first_q, first_d, prev_q, prev_d;
  logic [ClW-1:0]   got_q, got_d, c_q, c_d, steps_q, steps_d, freed_q, freed_d;
  logic [ClW-1:0]   free_q, free_d;
  logic [QuoW-1:0]  need_q, need_d;
  logic [1:0]       status_q, status_d;
  logic [DirDepth-1:0] valid_q, valid_d;
  logic             mv_q, mv_d;
  logic [23:0]      mdata_q, mdata_d;

  logic            lk_we;
  logic [CW-1:0]   lk_waddr;
  logic [ClW-1:0]  lk_wdata, lk_rdata;
  logic            dr_we;
  logic [DW-1:0]   dr_waddr;
  logic [DirW-1:0] dr_wdata, dr_rdata;
  div_req_t        dreq;
  div_rsp_t        drsp;

  logic fid_ok, oid_ok, fid_used, oid_free;

  fcca_ram #(.Width(ClW), .Depth(NUM_CLUSTERS)) u_link (
    .clk_i, .we_i(lk_we), .waddr_i(lk_waddr), .wdata_i(lk_wdata),
    .raddr_i(c_q[CW-1:0]), .rdata_o(lk_rdata)
  );

  fcca_ram #(.Width(DirW), .Depth(DirDepth)) u_dir (
    .clk_i, .we_i(dr_we), .waddr_i(dr_waddr), .wdata_i(dr_wdata),
    .raddr_i(fid_q[DW-1:0]), .rdata_o(dr_rdata)
  );

  fcca_div #(.ClusterBytes(CLUSTER_BYTES)) u_div (
    .clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp)
  );

  assign fid_ok   = (32'(fid_q) < NUM_FILES);
  assign oid_ok   = (32'(oid_q) < NUM_FILES);
  assign fid_used = fid_ok && valid_q[fid_q[DW-1:0]];
  assign oid_free = oid_ok && !valid_q[oid_q[DW-1:0]];

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = mdata_q;

  always_comb begin
    state_d = state_q;
    act_d = act_q; fid_d = fid_q; oid_d = oid_q; size_d = size_q;
    rd_size_d = rd_size_q; rd_first_d = rd_first_q;
    first_d = first_q; prev_d = prev_q; got_d = got_q; c_d = c_q;
    steps_d = steps_q; freed_d = freed_q; free_d = free_q; need_d = need_q;
    status_d = status_q; valid_d = valid_q;
    mv_d = mv_q; mdata_d = mdata_q;
    lk_we = 1'b0; lk_waddr = c_q[CW-1:0]; lk_wdata = '0;
    dr_we = 1'b0; dr_waddr = fid_q[DW-1:0]; dr_wdata = {size_q, first_q};
    dreq.start = 1'b0; dreq.dividend = '0;

    if (mv_q && m_axis_tready) mv_d = 1'b0;

    unique case (state_q)
      S_CLR: begin
        lk_we    = 1'b1;
        lk_wdata = (c_q == '0) ? EndMark : '0;
        if (c_q == '0) begin
          dr_we    = 1'b1;
          dr_waddr = '0;
          dr_wdata = {RootBytes, ClW'(0)};
        end
        c_d = c_q + 1'b1;
        if (c_q == NumCl - 1'b1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          act_d  = s_axis_tdata[2:0];
          fid_d  = s_axis_tdata[8:3];
          oid_d  = s_axis_tdata[14:9];
          size_d = s_axis_tdata[29:15];
          state_d = S_DREAD;
        end
      end
      S_DREAD: state_d = S_CHECK;
      S_CHECK: begin
        rd_first_d = dr_rdata[ClW-1:0];
        rd_size_d  = dr_rdata[DirW-1:ClW];
        status_d = StOk;
        first_d  = EndMark;
        need_d   = '0;
        freed_d  = '0;
        state_d  = S_DONE;
        case (act_q)
          ACT_NEW: begin
            if (!fid_ok || valid_q[fid_q[DW-1:0]]) status_d = StUsed;
            else begin
              dreq.start = 1'b1;
              dreq.dividend = QuoW'(size_q) + QuoW'(CLUSTER_BYTES - 1);
              state_d = S_DIV;
            end
          end
          ACT_DELETE: begin
            if (!fid_used) status_d = StMissing;
            else begin
              c_d = dr_rdata[ClW-1:0];
              steps_d = '0;
              state_d = S_DROP_RD;
            end
          end
          ACT_RENAME: begin
            if (!oid_free) status_d = StUsed;
            else if (!fid_used) status_d = StMissing;
            else state_d = S_COMMIT;
          end
          ACT_COPY: begin
            if (!fid_used) status_d = StMissing;
            else if (!oid_free) status_d = StUsed;
            else begin
              dreq.start = 1'b1;
              dreq.dividend = QuoW'(dr_rdata[DirW-1:ClW]) + QuoW'(CLUSTER_BYTES - 1);
              state_d = S_DIV;
            end
          end
          ACT_MODIFY: begin
            if (!fid_used) status_d = StMissing;
            else begin
              dreq.start = 1'b1;
              dreq.dividend = QuoW'(size_q) + QuoW'(CLUSTER_BYTES - 1);
              state_d = S_DIV;
            end
          end
          default: ;
        endcase
      end
      S_DIV: begin
        if (drsp.done) begin
          need_d = drsp.quotient;
          if (drsp.quotient > QuoW'(free_q)) begin
            status_d = StNoSpace;
            need_d   = '0;
            state_d  = S_DONE;
          end else begin
            c_d   = ClW'(1);
            got_d = '0;
            state_d = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        if (c_q < NumCl && QuoW'(got_q) != need_q) state_d = S_SCAN_CHK;
        else state_d = S_SCAN_END;
      end
      S_SCAN_CHK: begin
        if (lk_rdata == '0) begin
          if (got_q == '0) first_d = c_q;
          else begin
            lk_we    = 1'b1;
            lk_waddr = prev_q[CW-1:0];
            lk_wdata = c_q;
          end
          prev_d = c_q;
          got_d  = got_q + 1'b1;
        end
        c_d = c_q + 1'b1;
        state_d = S_SCAN_RD;
      end
      S_SCAN_END: begin
        if (got_q != '0) begin
          lk_we    = 1'b1;
          lk_waddr = prev_q[CW-1:0];
          lk_wdata = EndMark;
        end
        free_d = free_q - got_q;
        if (act_q == ACT_MODIFY) begin
          c_d = rd_first_q;
          steps_d = '0;
          state_d = S_DROP_RD;
        end else begin
          state_d = S_COMMIT;
        end
      end
      S_DROP_RD: begin
        if (c_q < NumCl && steps_q < NumCl) state_d = S_DROP_CHK;
        else state_d = S_COMMIT;
      end
      S_DROP_CHK: begin
        if (lk_rdata == '0) state_d = S_COMMIT;
        else begin
          // reserved cluster 0 is walked through but never freed
          if (c_q != '0) begin
            lk_we   = 1'b1;
            freed_d = freed_q + 1'b1;
            free_d  = free_q + 1'b1;
          end
          c_d = lk_rdata;
          steps_d = steps_q + 1'b1;
          state_d = S_DROP_RD;
        end
      end
      S_COMMIT: begin
        state_d = S_DONE;
        case (act_q)
          ACT_DELETE: begin
            valid_d[fid_q[DW-1:0]] = 1'b0;
            need_d = QuoW'(freed_q);
          end
          ACT_RENAME: begin
            dr_we    = 1'b1;
            dr_waddr = oid_q[DW-1:0];
            dr_wdata = {rd_size_q, rd_first_q};
            valid_d[fid_q[DW-1:0]] = 1'b0;
            valid_d[oid_q[DW-1:0]] = 1'b1;
            first_d = rd_first_q;
          end
          ACT_COPY: begin
            dr_we    = 1'b1;
            dr_waddr = oid_q[DW-1:0];
            dr_wdata = {rd_size_q, first_q};
            valid_d[oid_q[DW-1:0]] = 1'b1;
          end
          default: begin
            dr_we = 1'b1;
            valid_d[fid_q[DW-1:0]] = 1'b1;
          end
        endcase
      end
      S_DONE: begin
        if (!mv_q || m_axis_tready) begin
          mv_d    = 1'b1;
          mdata_d = {1'b0, need_q[8:0], first_q, status_q};
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      c_q     <= '0;
      free_q  <= NumCl - 1'b1;
      valid_q <= DirDepth'(1);
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      c_q     <= c_d;
      free_q  <= free_d;
      valid_q <= valid_d;
      mv_q    <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d; fid_q <= fid_d; oid_q <= oid_d; size_q <= size_d;
    rd_size_q <= rd_size_d; rd_first_q <= rd_first_d;
    first_q <= first_d; prev_q <= prev_d; got_q <= got_d;
    steps_q <= steps_d; freed_q <= freed_d; need_q <= need_d;
    status_q <= status_d; mdata_q <= mdata_d;
  end

endmodule

/* sv/fcca_checker.sv */
// Port-level checks of the FAT cluster chain allocator, bound to the top.
// Depends on fcca_pkg and fat_cluster_chain_allocator.
module fcca_checker
  import fcca_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed under stall");

  // failed commands report no chain and no clusters
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] != StOk |->
      m_axis_tdata[13:2] == EndMark && m_axis_tdata[22:14] == 9'd0)
    else $error("failed command reports clusters");

  // one command in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second command taken while busy");

  // padding bit of the result word is zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[23] == 1'b0)
    else $error("result padding set");

endmodule

bind fat_cluster_chain_allocator fcca_checker u_fcca_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

/* verif/fat_cluster_chain_allocator_checker.sv */
// Checker for the FAT cluster chain allocator: watches both streams, predicts
// each result word from its own copy of the table and directory. Uses fcca_pkg.
`timescale 1ns / 1ps
module fat_cluster_chain_allocator_checker
  import fcca_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  output int          fail_count_o,
  output int          pending_o
);
  localparam int NClus = DefNumClusters;
  localparam int NFile = DefNumFiles;
  localparam int CBytes = DefClusterBytes;

  logic [ClW-1:0]   fat_link [NClus];
  logic             dir_used [NFile];
  logic [ClW-1:0]   dir_first [NFile];
  logic [SizeW-1:0] dir_bytes [NFile];
  int               free_clusters;
  logic [23:0]      result_q [$];

  function automatic int clusters_needed(int bytes);
    return (bytes + CBytes - 1) / CBytes;
  endfunction

  function automatic int alloc_chain(int need);
    int first, prev, got;
    first = int'(EndMark); prev = int'(EndMark); got = 0;
    for (int c = 1; c < NClus && got < need; c++) begin
      if (fat_link[c] == 0) begin
        if (prev == int'(EndMark)) first = c;
        else fat_link[prev] = ClW'(c);
        fat_link[c] = EndMark;
        prev = c;
        got++;
      end
    end
    free_clusters -= got;
    return first;
  endfunction

  function automatic int free_chain(int c);
    int freed, steps, nxt;
    freed = 0; steps = 0;
    while (c < NClus && steps < NClus) begin
      nxt = int'(fat_link[c]);
      if (nxt == 0) break;
      if (c != 0) begin
        fat_link[c] = '0;
        freed++;
        free_clusters++;
      end
      c = nxt;
      steps++;
    end
    return freed;
  endfunction

  function automatic logic [23:0] predict_result(logic [31:0] w);
    logic [2:0] act;
    int fid, oid, bytes, need, first, count;
    logic [1:0] st;
    act = w[2:0]; fid = int'(w[8:3]); oid = int'(w[14:9]); bytes = int'(w[29:15]);
    st = StOk; first = int'(EndMark); count = 0;
    case (act)
      ACT_NEW: begin
        need = clusters_needed(bytes);
        if (fid >= NFile || dir_used[fid]) st = StUsed;
        else if (need > free_clusters) st = StNoSpace;
        else begin
          first = (need != 0) ? alloc_chain(need) : int'(EndMark);
          dir_used[fid] = 1'b1; dir_first[fid] = ClW'(first);
          dir_bytes[fid] = SizeW'(bytes);
          count = need;
        end
      end
      ACT_DELETE: begin
        if (fid >= NFile || !dir_used[fid]) st = StMissing;
        else begin
          count = free_chain(int'(dir_first[fid]));
          dir_used[fid] = 1'b0;
        end
      end
      ACT_RENAME: begin
        if (oid >= NFile || dir_used[oid]) st = StUsed;
        else if (fid >= NFile || !dir_used[fid]) st = StMissing;
        else begin
          dir_used[oid] = 1'b1; dir_first[oid] = dir_first[fid];
          dir_bytes[oid] = dir_bytes[fid]; dir_used[fid] = 1'b0;
          first = int'(dir_first[oid]);
        end
      end
      ACT_COPY: begin
        if (fid >= NFile || !dir_used[fid]) st = StMissing;
        else if (oid >= NFile || dir_used[oid]) st = StUsed;
        else begin
          need = clusters_needed(int'(dir_bytes[fid]));
          if (need > free_clusters) st = StNoSpace;
          else begin
            first = (need != 0) ? alloc_chain(need) : int'(EndMark);
            dir_used[oid] = 1'b1; dir_first[oid] = ClW'(first);
            dir_bytes[oid] = dir_bytes[fid];
            count = need;
          end
        end
      end
      ACT_MODIFY: begin
        need = clusters_needed(bytes);
        if (fid >= NFile || !dir_used[fid]) st = StMissing;
        else if (need > free_clusters) st = StNoSpace;
        else begin
          first = (need != 0) ? alloc_chain(need) : int'(EndMark);
          void'(free_chain(int'(dir_first[fid])));
          dir_first[fid] = ClW'(first); dir_bytes[fid] = SizeW'(bytes);
          count = need;
        end
      end
      default: ;
    endcase
    return {1'b0, count[8:0], first[11:0], st};
  endfunction

  assign pending_o = result_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [23:0] exp_w;
    if (!rst_ni) begin
      for (int i = 0; i < NClus; i++) fat_link[i] = '0;
      fat_link[0] = EndMark;
      for (int i = 0; i < NFile; i++) begin
        dir_used[i] = 1'b0; dir_first[i] = '0; dir_bytes[i] = '0;
      end
      dir_used[0] = 1'b1;
      dir_bytes[0] = RootBytes;
      free_clusters = NClus - 1;
      fail_count_o <= 0;
      result_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, m_axis_tdata);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_w = result_q.pop_front();
          if (exp_w[1:0] !== m_axis_tdata[1:0] || exp_w[13:2] !== m_axis_tdata[13:2] ||
              exp_w[22:14] !== m_axis_tdata[22:14]) begin
            $display("%0t: mismatch status/first/count expected %0d/%0d/%0d actual %0d/%0d/%0d",
                     $time, exp_w[1:0], exp_w[13:2], exp_w[22:14],
                     m_axis_tdata[1:0], m_axis_tdata[13:2], m_axis_tdata[22:14]);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      // prediction runs on blocking copies inside the functions
      if (s_axis_tvalid && s_axis_tready)
        result_q.insert(result_q.size(), predict_result(s_axis_tdata));
    end
  end
endmodule

/* verif/fat_cluster_chain_allocator_test.sv */
// Testbench top for the FAT cluster chain allocator: drives commands, stalls
// the result stream and gives the verdict. Uses fcca_pkg and the checker.
`timescale 1ns / 1ps
module fat_cluster_chain_allocator_test
  import fcca_pkg::*;
();

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [23:0] m_axis_tdata;
  int          fail_count, pending, cycle_cnt = 0;
  int          send_idle_pct = 26, recv_idle_pct = 70;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  fat_cluster_chain_allocator i_dut (.*);

  fat_cluster_chain_allocator_checker i_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending));

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (cycle_cnt > 3000000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // tvalid stays up after an accept unless the next word idles first
  task automatic send_cmd(action_e act, int fid, int oid, int bytes);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {2'b00, bytes[14:0], oid[5:0], fid[5:0], act};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // random handles and actions, a few undefined; mostly small sizes, some large ones and extremes
  task automatic random_cmd();
    int bytes, r;
    r = $urandom_range(99);
    if (r < 60) bytes = $urandom_range(4 * 512);
    else if (r < 90) bytes = $urandom_range(32767);
    else bytes = $urandom_range(1) ? 0 : 32767;
    if ($urandom_range(99) < 3)
      send_cmd(action_e'($urandom_range(7, 5)), $urandom_range(63), $urandom_range(63), bytes);
    else
      send_cmd(action_e'($urandom_range(4)), $urandom_range(63), $urandom_range(63), bytes);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: extremes, each action, each error path, root cluster handling
    send_cmd(ACT_NEW, 0, 0, 10);          // root handle used
    send_cmd(ACT_NEW, 1, 0, 0);           // zero size
    send_cmd(ACT_NEW, 2, 0, 1);
    send_cmd(ACT_NEW, 3, 0, 32767);       // 64 clusters
    send_cmd(ACT_NEW, 4, 0, 32767);
    send_cmd(ACT_NEW, 5, 0, 32767);
    send_cmd(ACT_NEW, 6, 0, 32767);       // short of space
    send_cmd(ACT_MODIFY, 5, 0, 32767);    // must fit alongside old chain
    send_cmd(ACT_DELETE, 7, 0, 0);        // missing
    send_cmd(ACT_RENAME, 2, 2, 0);        // same handle
    send_cmd(ACT_RENAME, 2, 63, 0);
    send_cmd(ACT_RENAME, 9, 10, 0);       // source missing
    send_cmd(ACT_COPY, 63, 62, 0);
    send_cmd(ACT_COPY, 63, 63, 0);
    send_cmd(ACT_COPY, 11, 12, 0);
    send_cmd(ACT_COPY, 1, 13, 0);         // zero-size copy
    send_cmd(ACT_COPY, 3, 14, 0);         // no space
    send_cmd(ACT_MODIFY, 0, 0, 1024);     // root chain holds cluster 0
    send_cmd(ACT_DELETE, 0, 0, 0);
    send_cmd(ACT_DELETE, 3, 0, 0);
    send_cmd(ACT_MODIFY, 4, 0, 0);
    send_cmd(ACT_MODIFY, 20, 0, 5);
    send_cmd(action_e'(7), 63, 63, 32767);
    send_cmd(action_e'(5), 0, 0, 0);
    for (int i = 0; i < 390; i++) random_cmd();
    send_idle_pct = 70; recv_idle_pct = 26;
    for (int i = 0; i < 390; i++) random_cmd();
    send_idle_pct = 0; recv_idle_pct = 0;
    for (int i = 0; i < 390; i++) random_cmd();
    s_axis_tvalid <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (1100) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
